>>> hdl/pse_pkg.sv
// Shared types, widths and codes of the prime sieve engine.
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  // Default ceiling of the sieve limit.
  localparam int MAX_LIMIT_DEF = 4095;

  // Field widths.
  localparam int LIMIT_W = 12;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 10;
  localparam int VALUE_W = 12;

  // Prime list store: primes up to the widest limit.
  localparam int LIST_DEPTH = 564;
  localparam int LIST_AW    = 10;

  // Smallest prime.
  localparam int SMALLEST_PRIME = 2;

  // Packed stream widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Command codes.
  localparam logic OP_SIEVE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [LIMIT_W-1:0] upper_limit;
    logic [INDEX_W-1:0] prime_index;
  } pse_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prime_count;
    logic [VALUE_W-1:0] prime_value;
    logic               valid_res;
  } pse_result_t;

endpackage

`default_nettype wire

>>> hdl/pse_flag_ram.sv
// Candidate flag memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pse_flag_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic          wd,
  input  wire logic          re,
  input  wire logic [AW-1:0] ra,
  output logic               rd
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pse_list_ram.sv
// Prime list memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pse_list_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [pse_pkg::LIST_AW-1:0] wa,
  input  wire logic [pse_pkg::VALUE_W-1:0] wd,
  input  wire logic                        re,
  input  wire logic [pse_pkg::LIST_AW-1:0] ra,
  output logic      [pse_pkg::VALUE_W-1:0] rd
);

  logic [pse_pkg::VALUE_W-1:0] mem [pse_pkg::LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pse_seq.sv
// Sieve sequencer: initialise, strike and collect over the flag and list memories, and serve list reads.
`timescale 1ns / 1ps
`default_nettype none

module pse_seq #(
  parameter int MAX_LIMIT = pse_pkg::MAX_LIMIT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  input  wire pse_pkg::pse_cmd_t    cmd,
  output logic                      idle,
  input  wire logic                 res_ready,
  output logic                      res_valid,
  output pse_pkg::pse_result_t      res
);

  localparam int NMAX  = (MAX_LIMIT < (1 << pse_pkg::LIMIT_W)) ? MAX_LIMIT
                                                               : (1 << pse_pkg::LIMIT_W) - 1;
  localparam int DEPTH = NMAX + 1;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_SQ       = 4'd2;
  localparam logic [3:0] S_TEST     = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_STRIKE   = 4'd5;
  localparam logic [3:0] S_COLL     = 4'd6;
  localparam logic [3:0] S_COLL_END = 4'd7;
  localparam logic [3:0] S_RD       = 4'd8;
  localparam logic [3:0] S_RDW      = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  logic [3:0]                    state_r, state_nxt;
  logic [AW-1:0]                 n_r, n_nxt;
  logic [AW:0]                   a_r, a_nxt;
  logic [AW-1:0]                 a_d_r, a_d_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [2*AW-1:0]               sq_r, sq_nxt;
  logic [AW:0]                   j_r, j_nxt;
  logic [pse_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pse_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [pse_pkg::INDEX_W-1:0]   idx_r, idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [pse_pkg::VALUE_W-1:0]   val_r, val_nxt;

  logic          f_we, f_wd, f_re, f_rd;
  logic [AW-1:0] f_wa, f_ra;
  logic                        l_we, l_re;
  logic [pse_pkg::LIST_AW-1:0] l_wa, l_ra;
  logic [pse_pkg::VALUE_W-1:0] l_wd, l_rd;
  logic [AW:0]                 j_sum;
  logic                        take;

  pse_flag_ram #(.DEPTH(DEPTH), .AW(AW)) u_flags (
    .clk(clk), .we(f_we), .wa(f_wa), .wd(f_wd), .re(f_re), .ra(f_ra), .rd(f_rd)
  );

  pse_list_ram u_list (
    .clk(clk), .we(l_we), .wa(l_wa), .wd(l_wd), .re(l_re), .ra(l_ra), .rd(l_rd)
  );

  assign j_sum = j_r + {1'b0, i_r};
  assign take  = pend_r && f_rd;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    a_nxt     = a_r;
    a_d_nxt   = a_d_r;
    pend_nxt  = pend_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    val_nxt   = val_r;
    f_we = 1'b0;
    f_wa = a_r[AW-1:0];
    f_wd = 1'b0;
    f_re = 1'b0;
    f_ra = i_r;
    l_we = 1'b0;
    l_wa = cnt_r[pse_pkg::LIST_AW-1:0];
    l_wd = pse_pkg::VALUE_W'(a_d_r);
    l_re = 1'b0;
    l_ra = idx_r[pse_pkg::LIST_AW-1:0];
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          idx_nxt = cmd.prime_index;
          if (32'(cmd.upper_limit) > 32'(NMAX)) begin
            n_nxt = AW'(NMAX);
          end else begin
            n_nxt = AW'(cmd.upper_limit);
          end
          a_nxt = '0;
          if (cmd.opcode == pse_pkg::OP_READ) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // 0 and 1 are not prime, the rest start as candidates
        f_we = 1'b1;
        f_wa = a_r[AW-1:0];
        f_wd = (a_r >= (AW+1)'(pse_pkg::SMALLEST_PRIME));
        a_nxt = a_r + 1'b1;
        if (a_r[AW-1:0] == n_r) begin
          i_nxt     = AW'(pse_pkg::SMALLEST_PRIME);
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sq_nxt    = i_r * i_r;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sq_r > (2*AW)'(n_r)) begin
          a_nxt     = (AW+1)'(pse_pkg::SMALLEST_PRIME);
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_COLL;
        end else begin
          f_re      = 1'b1;
          f_ra      = i_r;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (f_rd) begin
          // smaller multiples are already struck by smaller primes
          j_nxt     = sq_r[AW:0];
          state_nxt = S_STRIKE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_STRIKE: begin
        f_we  = 1'b1;
        f_wa  = j_r[AW-1:0];
        f_wd  = 1'b0;
        j_nxt = j_sum;
        if (j_sum > {1'b0, n_r}) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_COLL: begin
        if (take) begin
          l_we    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (a_r <= {1'b0, n_r}) begin
          f_re     = 1'b1;
          f_ra     = a_r[AW-1:0];
          a_d_nxt  = a_r[AW-1:0];
          pend_nxt = 1'b1;
          a_nxt    = a_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_COLL_END;
        end
      end
      S_COLL_END: begin
        if (take) begin
          l_we = 1'b1;
        end
        count_nxt = cnt_r + pse_pkg::COUNT_W'(take);
        pend_nxt  = 1'b0;
        hit_nxt   = 1'b1;
        val_nxt   = '0;
        state_nxt = S_RESP;
      end
      S_RD: begin
        hit_nxt   = (idx_r < count_r);
        l_re      = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        val_nxt   = hit_r ? l_rd : '0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
    end
    n_r   <= n_nxt;
    a_r   <= a_nxt;
    a_d_r <= a_d_nxt;
    i_r   <= i_nxt;
    sq_r  <= sq_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    val_r <= val_nxt;
  end

  assign idle            = (state_r == S_IDLE);
  assign res.prime_count = count_r;
  assign res.prime_value = val_r;
  assign res.valid_res   = hit_r;

endmodule

`default_nettype wire

>>> hdl/prime_sieve_engine_core.sv
// Top level of the prime sieve engine: stream ports, output register, sequencer.
//
// Usage: one request enters on the in_ stream, one result leaves on the out_ stream.
// in_tuser selects the command: OP_SIEVE runs the sieve up to in_tdata[11:0]
// (saturated at MAX_LIMIT), OP_READ returns the prime at list position in_tdata[21:12].
// Every request gives exactly one result: the count of the latest sieve, the prime
// value (zero for a sieve or an index out of range) and out_tuser as the valid flag.
// Steps: a read passes the list lookup and its registered read before it loads the
// output register. A sieve up to n writes every flag 0..n, then for each i with i*i <= n
// squares i, tests the square against n and reads flag i, striking the multiples of
// each prime p from p*p; it then reads flags 2..n to collect the primes into the list.
// The single port pair of the flag memory, one access per cycle, bounds the sieve.
// One request is worked on at a time; the next is taken as soon as the sequencer
// returns to idle, even while the previous result still waits in the output register.
// If the receiver stalls, hold the result in the output register and hold the
// sequencer in its response step until the register frees up.
// Reset (rst_n low, synchronous) empties the output register, idles the sequencer and
// clears the stored count, so a read before any sieve answers not valid.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_engine_core #(
  parameter int MAX_LIMIT = pse_pkg::MAX_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [11:0] upper_limit, [21:12] prime_index, [23:22] zero
  input  wire logic [pse_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  wire logic                            in_tuser,
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [9:0] prime_count, [21:10] prime_value, [23:22] zero
  output logic      [pse_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] valid_res
  output logic                                 out_tuser
);

  pse_pkg::pse_cmd_t    cmd;
  pse_pkg::pse_result_t res;
  logic                 seq_idle;
  logic                 res_ready;
  logic                 res_valid;

  logic                        out_valid_r, out_valid_nxt;
  logic [pse_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [pse_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                        out_flag_r, out_flag_nxt;

  // Unpack the request fields.
  assign cmd.opcode      = in_tuser;
  assign cmd.upper_limit = in_tdata[pse_pkg::LIMIT_W-1:0];
  assign cmd.prime_index = in_tdata[pse_pkg::LIMIT_W +: pse_pkg::INDEX_W];

  // Accept only while the sequencer idles.
  assign in_tready = seq_idle;

  // The sequencer may hand over a result when the output register is free or draining.
  assign res_ready = !out_valid_r || out_tready;

  pse_seq #(.MAX_LIMIT(MAX_LIMIT)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid && seq_idle),
    .cmd       (cmd),
    .idle      (seq_idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a new result, drop the old one once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = res.prime_count;
      out_value_nxt = res.prime_value;
      out_flag_nxt  = res.valid_res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_count_r <= out_count_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(pse_pkg::OUT_TDATA_W - pse_pkg::COUNT_W - pse_pkg::VALUE_W)'(0),
                       out_value_r, out_count_r};
  assign out_tuser  = out_flag_r;

endmodule

`default_nettype wire
